### hw/rtl/bcomp_pkg.sv
// Shared types, register codes and constants of the barometric compensation pipeline.
// No dependencies; every other file refers to this package by scoped names.
package bcomp_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTempCoef  = 2'd0,
    CfgPressLow  = 2'd1,
    CfgPressHigh = 2'd2,
    CfgPressNine = 2'd3
  } cfg_idx_e;

  // divider operand widths: dividend is the full 64-bit numerator, the
  // divisor magnitude comes from a 31-bit signed value
  localparam int unsigned NumW = 64;
  localparam int unsigned DenW = 31;

  localparam logic signed [32:0] FineOffset = 33'sd128000;
  localparam logic [20:0]        PressBase  = 21'd1048576;
  localparam logic [63:0]        NumScale   = 64'd3125;
  localparam logic [31:0]        TempRound  = 32'd128;
  localparam logic [63:0]        V1Bias     = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [23:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               divisor_zero;
  } out_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } coef_t;

  typedef struct packed {
    logic signed [31:0] fine;
    logic signed [23:0] tc;
    logic [19:0]        rp;
  } temp_res_t;

  typedef struct packed {
    logic signed [23:0] tc;
    logic               zero;
    logic               neg;
  } div_tag_t;

  localparam int unsigned TagW = $bits(div_tag_t);

  typedef struct packed {
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
    div_tag_t        tag;
  } div_in_t;

  typedef struct packed {
    logic [NumW-1:0] quo;
    div_tag_t        tag;
  } div_out_t;

endpackage

### hw/rtl/bcomp_temp.sv
// Temperature path: four stages from raw temperature to fine value and centidegrees.
// Depends on bcomp_pkg.
module bcomp_temp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  bcomp_pkg::in_t        data_i,
  input  bcomp_pkg::coef_t      coef_i,
  output logic                  valid_o,
  output bcomp_pkg::temp_res_t  data_o
);

  logic [3:0] vld_q;

  logic signed [17:0] d1_q, d1_d;
  logic signed [16:0] d2_q, d2_d;
  logic [19:0]        rp1_q, rp2_q, rp3_q;
  logic signed [33:0] m1_w, sq_w;
  logic signed [20:0] v1t_q, v1t3_q;
  logic signed [19:0] sq12_q;
  logic signed [35:0] m2_w;
  logic signed [17:0] v2t_q;
  logic signed [31:0] fine_w;
  logic [31:0]        scaled_w;
  bcomp_pkg::temp_res_t res_q, res_d;

  assign d1_d = $signed({1'b0, data_i.raw_temperature[19:3]}) - $signed({1'b0, coef_i.t1, 1'b0});
  assign d2_d = $signed({1'b0, data_i.raw_temperature[19:4]}) - $signed({1'b0, coef_i.t1});

  assign m1_w = d1_q * $signed(coef_i.t2);
  assign sq_w = d2_q * d2_q;
  assign m2_w = sq12_q * $signed(coef_i.t3);

  assign fine_w   = {{11{v1t3_q[20]}}, v1t3_q} + {{14{v2t_q[17]}}, v2t_q};
  assign scaled_w = {fine_w[29:0], 2'b00} + fine_w + bcomp_pkg::TempRound;

  always_comb begin
    res_d      = '0;
    res_d.fine = fine_w;
    res_d.tc   = scaled_w[31:8];
    res_d.rp   = rp3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // 32-bit wrap then arithmetic shift is a plain bit-select of the product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q   <= d1_d;
      d2_q   <= d2_d;
      rp1_q  <= data_i.raw_pressure;
      v1t_q  <= m1_w[31:11];
      sq12_q <= sq_w[31:12];
      rp2_q  <= rp1_q;
      v1t3_q <= v1t_q;
      v2t_q  <= m2_w[31:14];
      rp3_q  <= rp2_q;
      res_q  <= res_d;
    end
  end

  assign valid_o = vld_q[3];
  assign data_o  = res_q;

endmodule

### hw/rtl/bcomp_press_pre.sv
// Pressure front end: seven stages from fine temperature to divider operands.
// Depends on bcomp_pkg.
module bcomp_press_pre (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  bcomp_pkg::temp_res_t  data_i,
  input  bcomp_pkg::coef_t      coef_i,
  output logic                  valid_o,
  output bcomp_pkg::div_in_t    data_o
);

  logic [6:0] vld_q;

  // stage A
  logic signed [32:0] v1_w;
  logic signed [65:0] vsq_w;
  logic signed [48:0] vp5_w, vp2_w;
  logic [63:0]        vsq_q;
  logic signed [48:0] vp5_q, vp2_q, vp5b_q, vp2b_q;
  // stage B
  logic signed [63:0] a6_w, a3_w;
  logic [63:0]        a6_q, a3_q;
  // stage C
  logic [63:0]        v2_q, v2c_q, v1b_q;
  // stage D
  logic [63:0]        t_w, t_q;
  // stage E
  logic [20:0]        pb_w;
  logic [63:0]        diff_q;
  logic signed [30:0] v1c_q;
  logic               zero_e_q;
  // stage F
  logic [63:0]        num_q;
  logic [30:0]        md_q;
  logic               dn_q, zero_f_q;
  // stage G
  bcomp_pkg::div_in_t div_q, div_d;

  logic signed [23:0] tc_q [6];
  logic [19:0]        rp_q [4];

  assign v1_w  = $signed({data_i.fine[31], data_i.fine}) - bcomp_pkg::FineOffset;
  assign vsq_w = v1_w * v1_w;
  assign vp5_w = v1_w * $signed(coef_i.p5);
  assign vp2_w = v1_w * $signed(coef_i.p2);

  assign a6_w = $signed(vsq_q) * $signed(coef_i.p6);
  assign a3_w = $signed(vsq_q) * $signed(coef_i.p3);

  assign t_w  = (v1b_q + bcomp_pkg::V1Bias) * {48'd0, coef_i.p1};
  assign pb_w = bcomp_pkg::PressBase - {1'b0, rp_q[3]};

  always_comb begin
    div_d          = '0;
    div_d.num      = num_q[63] ? (64'd0 - num_q) : num_q;
    div_d.den      = md_q;
    div_d.tag.tc   = tc_q[5];
    div_d.tag.zero = zero_f_q;
    div_d.tag.neg  = num_q[63] ^ dn_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vsq_q    <= vsq_w[63:0];
      vp5_q    <= vp5_w;
      vp2_q    <= vp2_w;
      a6_q     <= a6_w;
      a3_q     <= a3_w;
      vp5b_q   <= vp5_q;
      vp2b_q   <= vp2_q;
      v2_q     <= a6_q + {vp5b_q[46:0], 17'd0}
                  + {{13{coef_i.p4[15]}}, coef_i.p4, 35'd0};
      v1b_q    <= {{8{a3_q[63]}}, a3_q[63:8]} + {{3{vp2b_q[48]}}, vp2b_q, 12'd0};
      t_q      <= t_w;
      v2c_q    <= v2_q;
      diff_q   <= {12'd0, pb_w, 31'd0} - v2c_q;
      v1c_q    <= t_q[63:33];
      zero_e_q <= (t_q[63:33] == 31'd0);
      num_q    <= diff_q * bcomp_pkg::NumScale;
      md_q     <= v1c_q[30] ? (31'd0 - v1c_q) : v1c_q;
      dn_q     <= v1c_q[30];
      zero_f_q <= zero_e_q;
      div_q    <= div_d;
      tc_q[0]  <= data_i.tc;
      rp_q[0]  <= data_i.rp;
      for (int i = 1; i < 6; i++) begin
        tc_q[i] <= tc_q[i-1];
      end
      for (int i = 1; i < 4; i++) begin
        rp_q[i] <= rp_q[i-1];
      end
    end
  end

  assign valid_o = vld_q[6];
  assign data_o  = div_q;

endmodule

### hw/rtl/bcomp_div.sv
// Pipelined restoring divider, one quotient bit per stage, tag carried alongside.
// Depends on bcomp_pkg for its default widths.
module bcomp_div #(
  parameter int unsigned NumW = bcomp_pkg::NumW,
  parameter int unsigned DenW = bcomp_pkg::DenW,
  parameter int unsigned TagW = bcomp_pkg::TagW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [TagW-1:0]  tag_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quo_o,
  output logic [TagW-1:0]  tag_o
);

  logic [DenW-1:0] rem_q [NumW];
  logic [NumW-1:0] quo_q [NumW];
  logic [DenW-1:0] den_q [NumW];
  logic [TagW-1:0] tag_q [NumW];
  logic            vld_q [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic [DenW-1:0] rem_in, den_in, rem_d;
    logic [NumW-1:0] quo_in;
    logic [TagW-1:0] tag_in;
    logic            vld_in, ge;
    logic [DenW:0]   trial, diff;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = num_i;
      assign den_in = den_i;
      assign tag_in = tag_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    assign trial = {rem_in, quo_in[NumW-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};
    assign rem_d = ge ? diff[DenW-1:0] : trial[DenW-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= {quo_in[NumW-2:0], ge};
        den_q[k] <= den_in;
        tag_q[k] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[NumW-1];
  assign quo_o   = quo_q[NumW-1];
  assign tag_o   = tag_q[NumW-1];

endmodule

### hw/rtl/bcomp_press_post.sv
// Pressure back end: sign fix of the quotient and the P7..P9 correction, six stages.
// Depends on bcomp_pkg.
module bcomp_press_post (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  bcomp_pkg::div_out_t   data_i,
  input  bcomp_pkg::coef_t      coef_i,
  output logic                  valid_o,
  output bcomp_pkg::out_t       data_o
);

  logic [5:0] vld_q;

  logic [63:0]        p_q [4];
  logic signed [23:0] tc_q [5];
  logic               zero_q [5];

  logic [63:0]        q_w;
  logic [63:0]        ll_q, sq_q, a_q, s_q;
  logic [31:0]        lh_q;
  logic signed [63:0] pb_w, a_w;
  logic [63:0]        pb_q, pb2_q, pb3_q;
  logic [31:0]        r_w;
  bcomp_pkg::out_t    out_q, out_d;

  assign q_w  = {{13{p_q[0][63]}}, p_q[0][63:13]};
  assign pb_w = $signed(p_q[0]) * $signed(coef_i.p8);
  assign a_w  = $signed(sq_q) * $signed(coef_i.p9);
  assign r_w  = s_q[39:8] + {{12{coef_i.p7[15]}}, coef_i.p7, 4'd0};

  always_comb begin
    out_d                   = '0;
    out_d.temperature_centi = tc_q[4];
    out_d.divisor_zero      = zero_q[4];
    out_d.pressure_q24_8    = zero_q[4] ? 32'd0 : r_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0]    <= data_i.tag.neg ? (64'd0 - data_i.quo) : data_i.quo;
      tc_q[0]   <= data_i.tag.tc;
      zero_q[0] <= data_i.tag.zero;
      for (int i = 1; i < 5; i++) begin
        tc_q[i]   <= tc_q[i-1];
        zero_q[i] <= zero_q[i-1];
      end
      for (int i = 1; i < 4; i++) begin
        p_q[i] <= p_q[i-1];
      end
      // low 64 bits of q*q from 32-bit halves
      ll_q  <= q_w[31:0] * q_w[31:0];
      lh_q  <= q_w[31:0] * q_w[63:32];
      pb_q  <= pb_w;
      sq_q  <= ll_q + {lh_q[30:0], 33'd0};
      pb2_q <= pb_q;
      a_q   <= a_w;
      pb3_q <= pb2_q;
      s_q   <= p_q[3] + {{25{a_q[63]}}, a_q[63:25]} + {{19{pb3_q[63]}}, pb3_q[63:19]};
      out_q <= out_d;
    end
  end

  assign valid_o = vld_q[5];
  assign data_o  = out_q;

endmodule

### hw/rtl/barometric_compensation.sv
// Barometric compensation: one raw temperature and pressure pair in, one compensated
// result out. A new transaction is taken every cycle while in_stall_o is low; the 64-stage
// pipelined divider forms the pressure quotient. The user must write coefficients through
// the configuration port only while the pipeline is empty; the block does not enforce it.
// An output register plus one skid entry decouple the sides; in_stall_o rises only when
// the skid entry is occupied, which freezes the whole pipeline until the output drains.
// Depends on bcomp_pkg, bcomp_temp, bcomp_press_pre, bcomp_div and bcomp_press_post.
module barometric_compensation (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bcomp_pkg::in_t                      in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bcomp_pkg::out_t                     out_data_o,
  input  logic                                cfg_we_i,
  input  logic [bcomp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bcomp_pkg::CfgDataW-1:0]      cfg_data_i
);

  logic [47:0] temp_coef_q;
  logic [63:0] press_low_q, press_high_q;
  logic [15:0] press_nine_q;
  bcomp_pkg::coef_t coef;

  logic en;
  logic temp_vld, pre_vld, div_vld, post_vld;
  bcomp_pkg::temp_res_t temp_res;
  bcomp_pkg::div_in_t   div_in;
  bcomp_pkg::div_out_t  div_out;
  bcomp_pkg::out_t      post_res;
  logic [bcomp_pkg::TagW-1:0] div_tag;
  logic [bcomp_pkg::NumW-1:0] div_quo;

  logic            out_v_q, skid_v_q, take;
  bcomp_pkg::out_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coef_q  <= '0;
      press_low_q  <= '0;
      press_high_q <= '0;
      press_nine_q <= '0;
    end else if (cfg_we_i) begin
      unique case (bcomp_pkg::cfg_idx_e'(cfg_idx_i))
        bcomp_pkg::CfgTempCoef:  temp_coef_q  <= cfg_data_i[47:0];
        bcomp_pkg::CfgPressLow:  press_low_q  <= cfg_data_i;
        bcomp_pkg::CfgPressHigh: press_high_q <= cfg_data_i;
        bcomp_pkg::CfgPressNine: press_nine_q <= cfg_data_i[15:0];
      endcase
    end
  end

  always_comb begin
    coef    = '0;
    coef.t1 = temp_coef_q[15:0];
    coef.t2 = temp_coef_q[31:16];
    coef.t3 = temp_coef_q[47:32];
    coef.p1 = press_low_q[15:0];
    coef.p2 = press_low_q[31:16];
    coef.p3 = press_low_q[47:32];
    coef.p4 = press_low_q[63:48];
    coef.p5 = press_high_q[15:0];
    coef.p6 = press_high_q[31:16];
    coef.p7 = press_high_q[47:32];
    coef.p8 = press_high_q[63:48];
    coef.p9 = press_nine_q;
  end

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  bcomp_temp u_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .coef_i  (coef),
    .valid_o (temp_vld),
    .data_o  (temp_res)
  );

  bcomp_press_pre u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (temp_vld),
    .data_i  (temp_res),
    .coef_i  (coef),
    .valid_o (pre_vld),
    .data_o  (div_in)
  );

  bcomp_div #(
    .NumW (bcomp_pkg::NumW),
    .DenW (bcomp_pkg::DenW),
    .TagW (bcomp_pkg::TagW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pre_vld),
    .num_i   (div_in.num),
    .den_i   (div_in.den),
    .tag_i   (div_in.tag),
    .valid_o (div_vld),
    .quo_o   (div_quo),
    .tag_o   (div_tag)
  );

  assign div_out = '{quo: div_quo, tag: bcomp_pkg::div_tag_t'(div_tag)};

  bcomp_press_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_vld),
    .data_i  (div_out),
    .coef_i  (coef),
    .valid_o (post_vld),
    .data_o  (post_res)
  );

  assign take = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (post_vld) begin
      if (!out_v_q || take) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  // drain the skid entry first; park the pipeline result there when output is held
  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (post_vld) begin
      if (!out_v_q || take) begin
        out_q <= post_res;
      end else begin
        skid_q <= post_res;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/bcomp_checker.sv
// Port-level checks of barometric_compensation, attached by the bind at the end.
// Depends on bcomp_pkg.
module bcomp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input bcomp_pkg::out_t                 out_data_o
);

  // a held result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("held output transaction changed");

  // a zero divisor forces pressure to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.divisor_zero |-> out_data_o.pressure_q24_8 == 32'd0)
    else $error("pressure not cleared on zero divisor");

  // input backpressure only while a result sits in the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // input backpressure only follows a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

endmodule

bind barometric_compensation bcomp_checker u_bcomp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### tb/tb_top.sv
// Self-checking testbench for barometric_compensation: drives sample pairs through the
// valid/stall channels, predicts each compensated result and compares every field.
// Depends on bcomp_pkg and the barometric_compensation RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned Latency    = 81;
  localparam int unsigned CycleLimit = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  bcomp_pkg::in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  bcomp_pkg::out_t out_data;
  logic      cfg_we = 1'b0;
  logic [bcomp_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [bcomp_pkg::CfgDataW-1:0] cfg_data = '0;

  // coefficient shadow used by the predictor
  logic [47:0] temp_coef = '0;
  logic [63:0] press_lo = '0;
  logic [63:0] press_hi = '0;
  logic [15:0] press_p9 = '0;

  bcomp_pkg::out_t pending_results[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_zero_div = 0;
  int unsigned n_cfg = 0;
  int unsigned cycles = 0;
  int unsigned hold_off = 0;
  bit          quiet = 1'b0;

  barometric_compensation u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] asr64(logic [63:0] v, int unsigned s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [31:0] asr32(logic [31:0] v, int unsigned s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [63:0] sext16(logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  function automatic bcomp_pkg::out_t compensate(logic [19:0] rt, logic [19:0] rp);
    logic [31:0] t1, t2, t3, d1, d2, sq, v1t, v2t, fine, tc;
    logic [63:0] v1, v2, acc, num, mn, md, quo, p, q, a, b;
    bcomp_pkg::out_t res;
    t1  = {16'b0, temp_coef[15:0]};
    t2  = {{16{temp_coef[31]}}, temp_coef[31:16]};
    t3  = {{16{temp_coef[47]}}, temp_coef[47:32]};
    d1  = {15'b0, rt[19:3]} - (t1 << 1);
    v1t = asr32(d1 * t2, 11);
    d2  = {16'b0, rt[19:4]} - t1;
    sq  = d2 * d2;
    v2t = asr32(asr32(sq, 12) * t3, 14);
    fine = v1t + v2t;
    tc   = asr32(fine * 32'd5 + 32'd128, 8);

    v1  = {{32{fine[31]}}, fine} - 64'd128000;
    v2  = v1 * v1 * sext16(press_hi[31:16]);
    v2  = v2 + ((v1 * sext16(press_hi[15:0])) << 17);
    v2  = v2 + (sext16(press_lo[63:48]) << 35);
    acc = v1 * v1 * sext16(press_lo[47:32]);
    v1  = asr64(acc, 8) + ((v1 * sext16(press_lo[31:16])) << 12);
    acc = ((64'd1 << 47) + v1) * {48'b0, press_lo[15:0]};
    v1  = asr64(acc, 33);

    res = '0;
    res.temperature_centi = tc[23:0];
    if (v1 == 64'd0) begin
      res.divisor_zero = 1'b1;
    end else begin
      num = (((64'd1048576 - {44'b0, rp}) << 31) - v2) * 64'd3125;
      mn  = num[63] ? -num : num;
      md  = v1[63] ? -v1 : v1;
      quo = mn / md;
      p   = (num[63] != v1[63]) ? -quo : quo;
      q   = asr64(p, 13);
      a   = asr64(sext16(press_p9) * q * q, 25);
      b   = asr64(sext16(press_hi[63:48]) * p, 19);
      p   = asr64(p + a + b, 8) + (sext16(press_hi[47:32]) << 4);
      res.pressure_q24_8 = p[31:0];
    end
    return res;
  endfunction

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int unsigned burst;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        hold_off--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(7) == 0) begin
        burst = $urandom_range(3, 1) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // check each accepted result against the oldest prediction
  initial begin
    bcomp_pkg::out_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (out_data.temperature_centi !== want.temperature_centi) begin
            errors++;
            $display("%0t: temperature_centi expected %h actual %h", $time,
                     want.temperature_centi, out_data.temperature_centi);
          end
          if (out_data.pressure_q24_8 !== want.pressure_q24_8) begin
            errors++;
            $display("%0t: pressure_q24_8 expected %h actual %h", $time,
                     want.pressure_q24_8, out_data.pressure_q24_8);
          end
          if (out_data.divisor_zero !== want.divisor_zero) begin
            errors++;
            $display("%0t: divisor_zero expected %b actual %b", $time,
                     want.divisor_zero, out_data.divisor_zero);
          end
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // offer one sample pair and hold it until the input accepts it
  task automatic send_sample(logic [19:0] rt, logic [19:0] rp);
    bcomp_pkg::out_t exp_res;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= '{raw_temperature: rt, raw_pressure: rp};
    do @(posedge clk_i); while (in_stall);
    exp_res = compensate(rt, rp);
    if (exp_res.divisor_zero) n_zero_div++;
    pending_results.push_back(exp_res);
    n_sent++;
    if (!quiet && $urandom_range(5) == 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat ($urandom_range(2, 0)) @(negedge clk_i);
    end
  endtask

  task automatic go_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (Latency + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(bcomp_pkg::cfg_idx_e idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      bcomp_pkg::CfgTempCoef:  temp_coef = data[47:0];
      bcomp_pkg::CfgPressLow:  press_lo  = data;
      bcomp_pkg::CfgPressHigh: press_hi  = data;
      bcomp_pkg::CfgPressNine: press_p9  = data[15:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic load_coefs(logic [47:0] t, logic [63:0] lo, logic [63:0] hi,
                            logic [15:0] p9);
    // random upper bits must be ignored by the narrower registers
    write_reg(bcomp_pkg::CfgTempCoef, {16'($urandom()), t});
    write_reg(bcomp_pkg::CfgPressLow, lo);
    write_reg(bcomp_pkg::CfgPressHigh, hi);
    write_reg(bcomp_pkg::CfgPressNine, {$urandom(), 16'($urandom()), p9});
  endtask

  task automatic load_typical();
    // T3 T2 T1 / P4 P3 P2 P1 / P8 P7 P6 P5 / P9 of a typical part
    load_coefs({16'hFC18, 16'd26435, 16'd27504},
               {16'd2855, 16'd3024, 16'hD643, 16'd36477},
               {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
  endtask

  task automatic test_reset_coefficients();
    // all coefficients zero: divisor is zero
    send_sample(20'h0, 20'h0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    go_idle();
  endtask

  task automatic test_field_extremes();
    load_typical();
    send_sample(20'h0, 20'h0);
    send_sample(20'hFFFFF, 20'h0);
    send_sample(20'h0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h7EFA0, 20'h65A30);
    send_sample(20'h80000, 20'h80000);
    send_sample(20'h55555, 20'hAAAAA);
    go_idle();
  endtask

  task automatic test_coefficient_extremes();
    load_coefs({3{16'hFFFF}}, {4{16'hFFFF}}, {4{16'hFFFF}}, 16'hFFFF);
    send_sample(20'hFFFFF, 20'h0);
    send_sample(20'h0, 20'hFFFFF);
    go_idle();
    load_coefs({3{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 16'h8000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h12345, 20'h0);
    go_idle();
    load_coefs({3{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF);
    send_sample(20'h0, 20'h0);
    send_sample(20'hFFFFF, 20'h54321);
    go_idle();
  endtask

  task automatic test_zero_divisor();
    // P1 of zero forces a zero divisor while temperature stays valid
    load_coefs({16'hFC18, 16'd26435, 16'd27504},
               {16'd2855, 16'd3024, 16'hD643, 16'd0},
               {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
    send_sample(20'h7EFA0, 20'h65A30);
    send_sample(20'hFFFFF, 20'h0);
    go_idle();
  endtask

  task automatic random_coefs();
    if ($urandom_range(1)) begin
      // perturb typical values so the pressure path stays in a sane range
      load_coefs({16'hFC18 + 16'($urandom_range(400)), 16'd26000 + 16'($urandom_range(900)),
                  16'd27000 + 16'($urandom_range(1000))},
                 {16'd2855, 16'd3024 + 16'($urandom_range(50)), 16'hD643,
                  16'd36000 + 16'($urandom_range(1000))},
                 {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'($urandom_range(8000)));
    end else begin
      load_coefs(48'({$urandom(), $urandom()}), {$urandom(), $urandom()},
                 {$urandom(), $urandom()}, 16'($urandom()));
    end
  endtask

  task automatic test_random_samples(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 100 == 0) begin
        go_idle();
        random_coefs();
      end
      if ($urandom_range(3) == 0)
        send_sample(20'($urandom()), 20'($urandom()));
      else
        send_sample(20'h60000 + 20'($urandom_range(20'h3FFFF)),
                    20'h40000 + 20'($urandom_range(20'h4FFFF)));
    end
    go_idle();
  endtask

  task automatic test_backpressure();
    // hold the output long enough that the pipeline fills and stalls the input
    load_typical();
    hold_off = 300;
    for (int unsigned i = 0; i < 150; i++)
      send_sample(20'($urandom()), 20'($urandom()));
    go_idle();
  endtask

  task automatic test_full_rate();
    quiet = 1'b1;
    random_coefs();
    for (int unsigned i = 0; i < 150; i++)
      send_sample(20'($urandom()), 20'($urandom()));
    go_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_coefficients();
    test_field_extremes();
    test_coefficient_extremes();
    test_zero_divisor();
    test_backpressure();
    test_random_samples(650);
    test_full_rate();
    $display("covered %0d sample pairs, %0d results checked, %0d with zero divisor",
             n_sent, n_checked, n_zero_div);
    $display("%0d register writes over extreme, typical and random calibrations", n_cfg);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors, %0d results missing", errors, pending_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### barometric_compensation.f
hw/rtl/bcomp_pkg.sv
hw/rtl/bcomp_temp.sv
hw/rtl/bcomp_press_pre.sv
hw/rtl/bcomp_div.sv
hw/rtl/bcomp_press_post.sv
hw/rtl/barometric_compensation.sv
hw/rtl/bcomp_checker.sv
tb/tb_top.sv
